// ----- hw/rtl/dos_pkg.sv -----
// ----------------------------------------------------------------------------
// dos_pkg
// Shared types and constants of the option scanner: status codes, register
// indexes, the queue entry and the result.
// ----------------------------------------------------------------------------
package dos_pkg;

   localparam int HDR_BYTES   = 4;
   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_FOUND     = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_TOO_SHORT = 2'd2,
      ST_TRUNCATED = 2'd3
   } dos_status_type;

   typedef enum logic {
      CSR_TARGET_TYPE = 1'b0,
      CSR_HEADER_SKIP = 1'b1
   } dos_csr_index_type;

   // one classified byte on its way from front to back
   typedef struct packed {
      logic [7:0]  data_byte;
      logic        first_byte;
      logic        last_byte;
      logic [15:0] message_length;
      logic        too_short;
   } dos_item_type;

   typedef struct packed {
      dos_status_type scan_status;
      logic [15:0]    value_offset;
      logic [15:0]    value_length;
   } dos_result_type;

endpackage

// ----- hw/rtl/dos_if.sv -----
// ----------------------------------------------------------------------------
// dos_if
// Valid/ready channels of the option scanner: message bytes, results and
// register writes.
// ----------------------------------------------------------------------------
interface dos_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic        first_byte;
   logic        last_byte;
   logic [15:0] message_length;

   modport source (output valid, data_byte, first_byte, last_byte, message_length,
                   input ready);
   modport sink (input valid, data_byte, first_byte, last_byte, message_length,
                 output ready);
endinterface

interface dos_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  scan_status;
   logic [15:0] value_offset;
   logic [15:0] value_length;

   modport source (output valid, scan_status, value_offset, value_length,
                   input ready);
   modport sink (input valid, scan_status, value_offset, value_length,
                 output ready);
endinterface

interface dos_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [15:0] wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

// ----- hw/rtl/dhcpv6_option_scanner.sv -----
// ----------------------------------------------------------------------------
// dhcpv6_option_scanner
// Finds the first option of a chosen type in a DHCPv6 message streamed one
// byte per transaction.
// ----------------------------------------------------------------------------
// req_if carries one message byte per transaction with first/last markers;
// message_length is taken with the first byte. rsp_if gives one transaction
// per message: found (body offset and length), not found, too short or
// truncated. csr_if writes target_type (index 0) and header_skip (index 1);
// it is always ready. It must be written only while no message is in flight;
// the block itself does not enforce this. A byte passes an input register,
// a four-entry queue and the scanner, which loads the output register that
// holds the result. One byte is taken every cycle while rsp_if does not stall;
// the scanner's per-byte counter update and length compare sets that rate.
// When rsp_if stalls, the queue fills and req_if drops ready after at most
// five more bytes; nothing is lost. Synchronous reset empties the pipeline,
// clears both registers and leaves an open message of length zero.
// ----------------------------------------------------------------------------
module dhcpv6_option_scanner import dos_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   dos_req_if.sink    req_if,
   dos_rsp_if.source  rsp_if,
   dos_csr_if.sink    csr_if
);

   logic [15:0]             target_type_ff;
   logic [5:0]              header_skip_ff;
   logic                    front_valid;
   logic                    front_ready;
   dos_item_type            front_item;
   logic                    queue_valid;
   logic                    queue_ready;
   dos_item_type            queue_item;
   logic [FIFO_CNT_W-1:0]   queue_fill;
   dos_result_type          result;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_type_ff <= '0;
         header_skip_ff <= '0;
      end else if (csr_if.valid) begin
         unique case (dos_csr_index_type'(csr_if.index))
            CSR_TARGET_TYPE: target_type_ff <= csr_if.wdata;
            CSR_HEADER_SKIP: header_skip_ff <= csr_if.wdata[5:0];
            default: ;
         endcase
      end
   end

   dos_front u_front (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (req_if.valid),
      .in_ready          (req_if.ready),
      .in_data_byte      (req_if.data_byte),
      .in_first_byte     (req_if.first_byte),
      .in_last_byte      (req_if.last_byte),
      .in_message_length (req_if.message_length),
      .header_skip       (header_skip_ff),
      .out_valid         (front_valid),
      .out_ready         (front_ready),
      .out_item          (front_item)
   );

   dos_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_item  (front_item),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_item   (queue_item),
      .fill       (queue_fill)
   );

   dos_back u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (queue_valid),
      .in_ready    (queue_ready),
      .in_item     (queue_item),
      .target_type (target_type_ff),
      .header_skip (header_skip_ff),
      .out_valid   (rsp_if.valid),
      .out_ready   (rsp_if.ready),
      .out_result  (result)
   );

   assign rsp_if.scan_status  = result.scan_status;
   assign rsp_if.value_offset = result.value_offset;
   assign rsp_if.value_length = result.value_length;

`ifndef NO_ASSERTIONS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      queue_fill <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("queue fill beyond depth");

   a_found_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && (rsp_if.scan_status == ST_FOUND)
      |-> rsp_if.value_offset >= 16'(HDR_BYTES))
      else $error("found body offset inside first header");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && (rsp_if.scan_status != ST_FOUND)
      |-> (rsp_if.value_offset == '0) && (rsp_if.value_length == '0))
      else $error("non-found result carries offset or length");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (queue_fill == FIFO_CNT_W'(FIFO_DEPTH)) && front_valid |=> front_valid)
      else $error("input stage dropped a transaction while queue full");
`endif

endmodule

// ----- hw/rtl/dos_front.sv -----
// ----------------------------------------------------------------------------
// dos_front
// Input stage: registers each incoming byte and flags a message that is too
// short to hold one option header past the skipped bytes.
// ----------------------------------------------------------------------------
module dos_front import dos_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  logic [7:0]   in_data_byte,
   input  logic         in_first_byte,
   input  logic         in_last_byte,
   input  logic [15:0]  in_message_length,
   input  logic [5:0]   header_skip,
   output logic         out_valid,
   input  logic         out_ready,
   output dos_item_type out_item
);

   logic         valid_ff;
   logic         valid_in;
   dos_item_type item_ff;
   dos_item_type item_in;
   logic [15:0]  min_length;

   assign min_length = 16'(header_skip) + 16'(HDR_BYTES);
   assign in_ready   = !valid_ff || out_ready;

   always_comb begin
      item_in.data_byte      = in_data_byte;
      item_in.first_byte     = in_first_byte;
      item_in.last_byte      = in_last_byte;
      item_in.message_length = in_message_length;
      item_in.too_short      = in_first_byte && (in_message_length < min_length);
      valid_in = valid_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ----- hw/rtl/dos_fifo.sv -----
// ----------------------------------------------------------------------------
// dos_fifo
// Short queue of classified bytes between the input stage and the scanner.
// ----------------------------------------------------------------------------
module dos_fifo import dos_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   output logic         push_ready,
   input  dos_item_type push_item,
   output logic         pop_valid,
   input  logic         pop_ready,
   output dos_item_type pop_item,
   output logic [FIFO_CNT_W-1:0] fill
);

   dos_item_type            mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff;
   logic [FIFO_CNT_W-1:0]   count_ff;
   logic [FIFO_CNT_W-1:0]   count_in;
   logic                    do_push;
   logic                    do_pop;

   assign push_ready = count_ff != FIFO_CNT_W'(FIFO_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign fill       = count_ff;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- hw/rtl/dos_back.sv -----
// ----------------------------------------------------------------------------
// dos_back
// Scanner: walks option headers byte by byte, skips option bodies and holds
// the one result of each message in an output register.
// ----------------------------------------------------------------------------
module dos_back import dos_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  dos_item_type   in_item,
   input  logic [15:0]    target_type,
   input  logic [5:0]     header_skip,
   output logic           out_valid,
   input  logic           out_ready,
   output dos_result_type out_result
);

   logic [15:0]    pos_ff,   pos_in;
   logic [15:0]    mlen_ff,  mlen_in;
   logic [1:0]     hcount_ff, hcount_in;
   logic [23:0]    hshift_ff, hshift_in;
   logic [15:0]    body_ff,  body_in;
   logic           rep_ff,   rep_in;
   logic           out_valid_ff, out_valid_in;
   dos_result_type result_ff;

   logic [15:0]    pos_e;
   logic [15:0]    mlen_e;
   logic [1:0]     hcount_e;
   logic [23:0]    hshift_e;
   logic [15:0]    body_e;
   logic           rep_e;
   logic           res_valid;
   dos_result_type res;
   logic [15:0]    opt_type;
   logic [15:0]    opt_len;
   logic [15:0]    left;
   logic           take;

   assign in_ready = !out_valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      pos_e    = in_item.first_byte ? '0 : pos_ff;
      mlen_e   = in_item.first_byte ? in_item.message_length : mlen_ff;
      hcount_e = in_item.first_byte ? '0 : hcount_ff;
      hshift_e = in_item.first_byte ? '0 : hshift_ff;
      body_e   = in_item.first_byte ? '0 : body_ff;
      rep_e    = in_item.first_byte ? 1'b0 : rep_ff;

      opt_type = hshift_e[23:8];
      opt_len  = {hshift_e[7:0], in_item.data_byte};
      left     = mlen_e - pos_e - 16'd1;

      hcount_in = hcount_e;
      hshift_in = hshift_e;
      body_in   = body_e;
      res_valid = 1'b0;
      res.scan_status  = ST_NOT_FOUND;
      res.value_offset = '0;
      res.value_length = '0;

      if (in_item.too_short) begin
         res_valid       = 1'b1;
         res.scan_status = ST_TOO_SHORT;
      end else if (!rep_e && (pos_e < mlen_e) && (pos_e >= 16'(header_skip))) begin
         if (body_e != '0) begin
            body_in = body_e - 16'd1;
         end else begin
            hshift_in = {hshift_e[15:0], in_item.data_byte};
            hcount_in = hcount_e + 2'd1;
            if (hcount_e == 2'd3) begin
               priority if (opt_len > left) begin
                  res_valid       = 1'b1;
                  res.scan_status = ST_TRUNCATED;
               end else if (opt_type == target_type) begin
                  res_valid        = 1'b1;
                  res.scan_status  = ST_FOUND;
                  res.value_offset = pos_e + 16'd1;
                  res.value_length = opt_len;
               end else begin
                  body_in = opt_len;
               end
            end
         end
      end

      rep_in  = rep_e || res_valid;
      pos_in  = (pos_e == 16'hffff) ? pos_e : pos_e + 16'd1;
      mlen_in = mlen_e;
      if (in_item.last_byte) begin
         if (!rep_in) begin
            res_valid = 1'b1;
         end
         rep_in = 1'b1;
      end

      out_valid_in = out_valid_ff;
      if (take && res_valid) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         mlen_ff      <= '0;
         hcount_ff    <= '0;
         hshift_ff    <= '0;
         body_ff      <= '0;
         rep_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (take) begin
            pos_ff    <= pos_in;
            mlen_ff   <= mlen_in;
            hcount_ff <= hcount_in;
            hshift_ff <= hshift_in;
            body_ff   <= body_in;
            rep_ff    <= rep_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && res_valid) begin
         result_ff <= res;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_result = result_ff;

endmodule
